>>> hdl/base64_stream_decoder_assert.svh
// Assertion macros used by the base64 stream decoder checker
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the checker clock, off during reset
`define B64SD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b64sd check failed");

// Next-cycle implication, sampled on the checker clock, off during reset
`define B64SD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b64sd check failed");

`endif

>>> hdl/b64sd_pkg.sv
// Package: shared types, codes and the character map of the base64 stream decoder
`timescale 1ns / 1ps

package b64sd_pkg;

    localparam int unsigned APB_AW = 3;

    localparam logic [APB_AW-3:0] REG_IDX_STRICT = '0;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [2:0] ST_DATA       = 3'd0;
    localparam logic [2:0] ST_PADDED     = 3'd1;
    localparam logic [2:0] ST_CLEAN      = 3'd2;
    localparam logic [2:0] ST_INCOMPLETE = 3'd3;
    localparam logic [2:0] ST_ILLEGAL    = 3'd4;

    // One run of results caused by a single input transfer
    typedef struct packed {
        logic [23:0] data;
        logic [1:0]  nbytes;
        logic        is_status;
        logic [2:0]  status;
    } t_run;

    // bit 6 set: illegal character; bits 5:0 the sextet value
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] v;
        logic       bad;
        v   = 8'd0;
        bad = 1'b0;
        if (c inside {[8'h41:8'h5A]}) begin
            v = c - 8'h41;
        end else if (c inside {[8'h61:8'h7A]}) begin
            v = c - 8'h47;
        end else if (c inside {[8'h30:8'h39]}) begin
            v = c + 8'h04;
        end else if (c == CHAR_PLUS) begin
            v = 8'd62;
        end else if (c == CHAR_SLASH) begin
            v = 8'd63;
        end else if (c == CHAR_PAD) begin
            v = 8'd0;
        end else begin
            bad = 1'b1;
        end
        return {bad, v[5:0]};
    endfunction

endpackage

>>> hdl/b64sd_in_if.sv
// Interface: text input channel (one character or end marker per transfer)
`timescale 1ns / 1ps

interface b64sd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_stream;

    modport source (output valid, output text_byte, output end_of_stream, input ready);
    modport sink   (input valid, input text_byte, input end_of_stream, output ready);
endinterface

>>> hdl/b64sd_out_if.sv
// Interface: decoded result channel (data byte or end-of-stream status per transfer)
`timescale 1ns / 1ps

interface b64sd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic [2:0] status;
    logic       last_of_run;

    modport source (output valid, output out_byte, output is_status, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input is_status, input status,
                    input last_of_run, output ready);
endinterface

>>> hdl/base64_stream_decoder.sv
// Timing: a result is registered into the result queue before it shows on o_data.
// Without stalls: one input transfer per cycle; a group's bytes leave one per cycle.
// i_text.ready drops only while one run is draining and a second waits in the skid slot.
// Reset (i_rst_n low, synchronous): group, phase and queue cleared, strict_check set to 1.
// Top level: base64 text stream decoder with APB configuration port
`timescale 1ns / 1ps

module base64_stream_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    b64sd_in_if.sink                        i_text,
    b64sd_out_if.source                     o_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [b64sd_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic            r_strict;
    logic            w_reg_sel;
    logic            w_accept;
    logic            w_space;
    logic            w_run_valid;
    b64sd_pkg::t_run w_run;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[b64sd_pkg::APB_AW-1:2] == b64sd_pkg::REG_IDX_STRICT);
    assign prdata    = w_reg_sel ? {31'd0, r_strict} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_strict <= pwdata[0];
        end
    end

    assign i_text.ready = w_space;
    assign w_accept     = i_text.valid && w_space;

    b64sd_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_text_byte     (i_text.text_byte),
        .i_end_of_stream (i_text.end_of_stream),
        .i_strict        (r_strict),
        .o_run_valid     (w_run_valid),
        .o_run           (w_run)
    );

    b64sd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (w_run_valid),
        .i_run       (w_run),
        .o_space     (w_space),
        .o_valid     (o_data.valid),
        .i_ready     (o_data.ready),
        .o_byte      (o_data.out_byte),
        .o_is_status (o_data.is_status),
        .o_status    (o_data.status),
        .o_last      (o_data.last_of_run)
    );

endmodule

>>> hdl/b64sd_decode.sv
// Character decode and group assembly: holds the sextet group and stream phase
`timescale 1ns / 1ps

module b64sd_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_stream,
    input  logic             i_strict,
    output logic             o_run_valid,
    output b64sd_pkg::t_run  o_run
);

    typedef enum logic [1:0] {
        PH_ACTIVE  = 2'd0,
        PH_PADDED  = 2'd1,
        PH_ILLEGAL = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_count, n_count;
    logic [17:0] r_accum, n_accum;
    logic        r_third_pad, n_third_pad;

    logic [6:0]  w_sx;
    logic        w_is_pad;
    logic [2:0]  w_eos_status;

    assign w_sx     = b64sd_pkg::char_to_sextet(i_text_byte);
    assign w_is_pad = (i_text_byte == b64sd_pkg::CHAR_PAD);

    always_comb begin
        case (r_phase)
            PH_ACTIVE: begin
                w_eos_status = (i_strict && (r_count != 2'd0)) ?
                               b64sd_pkg::ST_INCOMPLETE : b64sd_pkg::ST_CLEAN;
            end
            PH_PADDED: w_eos_status = b64sd_pkg::ST_PADDED;
            default:   w_eos_status = b64sd_pkg::ST_ILLEGAL;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_accum     = r_accum;
        n_third_pad = r_third_pad;
        o_run_valid = 1'b0;
        o_run       = '0;
        if (i_accept) begin
            if (i_end_of_stream) begin
                o_run_valid     = 1'b1;
                o_run.nbytes    = 2'd1;
                o_run.is_status = 1'b1;
                o_run.status    = w_eos_status;
                n_phase         = PH_ACTIVE;
                n_count         = 2'd0;
                n_accum         = '0;
                n_third_pad     = 1'b0;
            end else if (r_phase == PH_ACTIVE && i_text_byte > b64sd_pkg::CHAR_SPACE) begin
                if (w_sx[6]) begin
                    if (i_strict) begin
                        n_phase = PH_ILLEGAL;
                    end
                end else if (r_count != 2'd3) begin
                    if (r_count == 2'd2 && w_is_pad) begin
                        n_third_pad = 1'b1;
                    end
                    n_accum = {r_accum[11:0], w_sx[5:0]};
                    n_count = r_count + 2'd1;
                end else begin
                    // group complete: padding trims the run and ends the stream
                    o_run_valid  = 1'b1;
                    o_run.data   = {r_accum, w_sx[5:0]};
                    o_run.nbytes = r_third_pad ? 2'd1 : (w_is_pad ? 2'd2 : 2'd3);
                    if (r_third_pad || w_is_pad) begin
                        n_phase = PH_PADDED;
                    end
                    n_count     = 2'd0;
                    n_accum     = '0;
                    n_third_pad = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ACTIVE;
            r_count     <= 2'd0;
            r_accum     <= '0;
            r_third_pad <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_accum     <= n_accum;
            r_third_pad <= n_third_pad;
        end
    end

endmodule

>>> hdl/b64sd_outq.sv
// Result queue: head run that is being emitted byte by byte, plus one skid run
`timescale 1ns / 1ps

module b64sd_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_run_valid,
    input  b64sd_pkg::t_run  i_run,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_is_status,
    output logic [2:0]       o_status,
    output logic             o_last
);

    logic            r_head_valid;
    logic            r_skid_valid;
    logic [1:0]      r_idx;
    b64sd_pkg::t_run r_head;
    b64sd_pkg::t_run r_skid;

    logic w_fire;
    logic w_pop;
    logic w_head_free;

    assign o_last      = (r_idx == (r_head.nbytes - 2'd1));
    assign w_fire      = r_head_valid & i_ready;
    assign w_pop       = w_fire & o_last;
    assign w_head_free = !r_head_valid || w_pop;

    // new runs only arrive while the skid slot is empty
    assign o_space     = !r_skid_valid;

    assign o_valid     = r_head_valid;
    assign o_is_status = r_head.is_status;
    assign o_status    = r_head.status;

    always_comb begin
        case (r_idx)
            2'd0:    o_byte = r_head.data[23:16];
            2'd1:    o_byte = r_head.data[15:8];
            default: o_byte = r_head.data[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
            r_idx        <= 2'd0;
        end else if (w_head_free) begin
            r_idx <= 2'd0;
            if (r_skid_valid) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_head_valid <= i_run_valid;
            end
        end else begin
            if (w_fire) begin
                r_idx <= r_idx + 2'd1;
            end
            if (i_run_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_head_free) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
            end else if (i_run_valid) begin
                r_head <= i_run;
            end
        end else if (i_run_valid) begin
            r_skid <= i_run;
        end
    end

endmodule

>>> hdl/b64sd_checker.sv
// Port-level checker for the base64 stream decoder, bound to the top level
`timescale 1ns / 1ps
`include "base64_stream_decoder_assert.svh"

module b64sd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_is_status,
    input logic [2:0] i_status,
    input logic       i_last
);

    // a status result is always a single-result run with a zero byte
    `B64SD_ASSERT_NOW(a_status_shape, i_out_valid && i_is_status, i_last && (i_out_byte == 8'd0))

    `B64SD_ASSERT_NOW(a_data_code, i_out_valid && !i_is_status, i_status == b64sd_pkg::ST_DATA)

    `B64SD_ASSERT_NOW(a_status_code, i_out_valid && i_is_status, (i_status == b64sd_pkg::ST_PADDED) || (i_status == b64sd_pkg::ST_CLEAN) || (i_status == b64sd_pkg::ST_INCOMPLETE) || (i_status == b64sd_pkg::ST_ILLEGAL))

    `B64SD_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_status) && $stable(i_last))

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_data.valid),
    .i_out_ready (o_data.ready),
    .i_out_byte  (o_data.out_byte),
    .i_is_status (o_data.is_status),
    .i_status    (o_data.status),
    .i_last      (o_data.last_of_run)
);
